FILE: sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types, constants and round functions for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  // Sequencer states of the engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sha1_state_t;

  // Initial chaining value, H0 in the lowest slot.
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_POS     = 6'd63;
  localparam logic [6:0] LAST_ROUND   = 7'd79;
  localparam int         DIGEST_WORDS = 5;
  localparam logic [2:0] LAST_WORD    = 3'd4;

  // Round group: 0 for rounds 0..19, 1 for 20..39, 2 for 40..59, 3 above.
  function automatic logic [1:0] round_group(input logic [6:0] rnd);
    logic [1:0] grp;
    if (rnd < 7'd20) begin
      grp = 2'd0;
    end else if (rnd < 7'd40) begin
      grp = 2'd1;
    end else if (rnd < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
    return grp;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] grp);
    logic [31:0] k;
    case (grp)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  // Choose, parity and majority functions of the rounds.
  function automatic logic [31:0] round_func(input logic [1:0]  grp,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha1_hash_engine_core.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine core
// Packs message bytes into 512-bit blocks, runs the SHA-1 compression with
// one shared round unit, pads the message and returns the five digest words.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                   Handshake
//  in_      input      message_byte, byte_present, end_of_message  valid/ready
//  out_     output     digest_word, word_number, final_word        valid/ready
//
// The 64th byte of a block starts the compression: 80 rounds in ST_ROUND,
// then the fold in ST_FOLD. An end transaction pads one byte a cycle, except
// while a block is compressed, through the same byte path, runs one or two
// more blocks, then offers five digest words.
// Input is not ready while a block, padding or digest output is in progress.
// Reset is synchronous; afterwards the engine starts from the initial value.
`default_nettype none

module sha1_hash_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_message_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_number,
  output logic             out_final_word
);

  sha1_pkg::sha1_state_t state_r, state_nxt;

  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [31:0] h_r [sha1_pkg::DIGEST_WORDS];
  logic [31:0] h_nxt [sha1_pkg::DIGEST_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [63:0] bit_total_r, bit_total_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  word_r, word_nxt;
  logic        pad_pend_r, pad_pend_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_r, len_nxt;

  logic        put_en;
  logic [7:0]  put_byte;
  logic [7:0]  len_byte;
  logic [1:0]  grp;
  logic [31:0] w_new;
  logic [31:0] round_sum;
  logic        block_done;

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_byte = bit_total_r[{~pos_r[2:0], 3'b000} +: 8];

  assign grp   = sha1_pkg::round_group(rnd_r);
  assign w_new = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign round_sum = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_func(grp, b_r, c_r, d_r)
                   + e_r + win_r[0] + sha1_pkg::round_const(grp);

  assign in_ready        = (state_r == sha1_pkg::ST_IDLE);
  assign out_valid       = (state_r == sha1_pkg::ST_OUT);
  assign out_digest_word = h_r[word_r];
  assign out_word_number = word_r;
  assign out_final_word  = (word_r == sha1_pkg::LAST_WORD);

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    bit_total_nxt = bit_total_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    word_nxt      = word_r;
    pad_pend_nxt  = pad_pend_r;
    pad_first_nxt = pad_first_r;
    len_nxt       = len_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end
    for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
      h_nxt[i] = h_r[i];
    end
    put_en   = 1'b0;
    put_byte = in_message_byte;

    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) begin
          put_en = in_byte_present;
          if (in_byte_present) begin
            bit_total_nxt = bit_total_r + 64'd8;
          end
          if (in_end_of_message) begin
            pad_pend_nxt  = 1'b1;
            pad_first_nxt = 1'b1;
            state_nxt     = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (pad_first_r) begin
          put_byte      = sha1_pkg::PAD_BYTE;
          pad_first_nxt = 1'b0;
        end else if (len_r || pos_r == sha1_pkg::LEN_POS) begin
          put_byte = len_byte;
          len_nxt  = 1'b1;
        end else begin
          put_byte = 8'h00;
        end
      end
      sha1_pkg::ST_ROUND: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        b_nxt = a_r;
        a_nxt = round_sum;
        // The window always holds W[t] .. W[t+15]; W[t+16] enters at the top.
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {w_new[30:0], w_new[31]};
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (len_r) begin
          word_nxt  = '0;
          state_nxt = sha1_pkg::ST_OUT;
        end else if (pad_pend_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_ready) begin
          word_nxt = word_r + 3'd1;
          if (word_r == sha1_pkg::LAST_WORD) begin
            word_nxt      = '0;
            bit_total_nxt = '0;
            pos_nxt       = '0;
            pad_pend_nxt  = 1'b0;
            pad_first_nxt = 1'b0;
            len_nxt       = 1'b0;
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
              h_nxt[i] = sha1_pkg::SHA1_IV[i];
            end
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase

    // Byte packing, shared by message bytes and padding bytes.
    block_done = put_en && (pos_r == sha1_pkg::LAST_POS);
    if (put_en) begin
      pos_nxt = pos_r + 6'd1;
      acc_nxt = {acc_r[15:0], put_byte};
      if (pos_r[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {acc_r, put_byte};
      end
    end
    if (block_done) begin
      a_nxt     = h_r[0];
      b_nxt     = h_r[1];
      c_nxt     = h_r[2];
      d_nxt     = h_r[3];
      e_nxt     = h_r[4];
      rnd_nxt   = '0;
      state_nxt = sha1_pkg::ST_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      bit_total_r <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      word_r      <= '0;
      pad_pend_r  <= 1'b0;
      pad_first_r <= 1'b0;
      len_r       <= 1'b0;
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
        h_r[i] <= sha1_pkg::SHA1_IV[i];
      end
    end else begin
      state_r     <= state_nxt;
      bit_total_r <= bit_total_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      word_r      <= word_nxt;
      pad_pend_r  <= pad_pend_nxt;
      pad_first_r <= pad_first_nxt;
      len_r       <= len_nxt;
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digest words are offered");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_ROUND) |-> (rnd_r <= sha1_pkg::LAST_ROUND))
    else $error("round counter beyond the last round");

  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_word == (out_word_number == sha1_pkg::LAST_WORD)))
    else $error("final word flag does not match the word number");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_final_word) |=>
      (h_r[0] == sha1_pkg::SHA1_IV[0] && bit_total_r == 64'd0 && pos_r == 6'd0))
    else $error("engine did not restart after the last digest word");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sha1_hash_engine_core_test.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine core testbench
// Streams messages byte by byte into the engine and checks every digest word
// against a behavioral SHA-1 predictor kept in step with the accepted input,
// or a published digest on marked rows. A short table covers the empty message,
// known short messages and ignored transactions. Random messages follow, also
// at padding boundaries, with sender and receiver stalls in two of three phases.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine_core_test;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int ITEM_TARGET    = 350;
  localparam int DRAIN_CYCLES   = 400;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DIRECTED_ROWS  = 18;

  localparam logic [31:0] K_CHOOSE = 32'h5A827999;
  localparam logic [31:0] K_PARITY = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJOR  = 32'h8F1BBCDC;
  localparam logic [31:0] K_LAST   = 32'hCA62C1D6;

  // Published digests, H0 in the top word.
  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
  localparam logic [159:0] NO_DIGEST    = '0;

  typedef struct packed {
    logic [7:0]   message_byte;
    logic         byte_present;
    logic         end_of_message;
    logic         typed;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_message_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_final_word;

  sha1_hash_engine_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_final_word    (out_final_word)
  );

  // Predictor state.
  logic [31:0] msg_words [16];
  logic [31:0] chain [5];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  digest_word_t digest_q [$];
  int fail_count;
  int item_count;
  int send_idle_pct;
  int take_idle_pct;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message straight after reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // no byte, no end: ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // last byte rides on the end
    '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // byte field must be ignored
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h7F, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h01, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // ignored in mid message
    '{8'hFE, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h55, 1'b0, 1'b1, 1'b1, ABC_DIGEST}     // same text closed by an empty end
  };

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int k = 0; k < 5; k++) chain[k] = sha1_pkg::SHA1_IV[k];
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    w = msg_words;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        w[s] = rotl32(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJOR;
      end else begin
        f = b ^ c ^ d;
        k = K_LAST;
      end
      t = rotl32(a, 5) + f + e + w[s] + k;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Bytes land big-endian; the first byte of a word clears the stale word.
  function automatic void absorb_byte(input logic [7:0] data);
    int lane;
    lane = 3 - int'(fill_pos[1:0]);
    if (fill_pos[1:0] == 2'd0) msg_words[fill_pos[5:2]] = '0;
    msg_words[fill_pos[5:2]][8 * lane +: 8] = data;
    fill_pos++;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  // Returns 1 and the digest when the transaction closes a message.
  function automatic bit hash_item(input logic [7:0] data, input logic present,
                                   input logic last, output logic [159:0] digest);
    digest = '0;
    if (present) begin
      msg_bits += 64'd8;
      absorb_byte(data);
    end
    if (!last) return 1'b0;
    absorb_byte(sha1_pkg::PAD_BYTE);
    while (fill_pos != sha1_pkg::LEN_POS) absorb_byte(8'h00);
    msg_words[14] = msg_bits[63:32];
    msg_words[15] = msg_bits[31:0];
    compress_block();
    digest = {chain[0], chain[1], chain[2], chain[3], chain[4]};
    restart_hash();
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] data, input logic present, input logic last,
                           input logic typed, input logic [159:0] typed_digest);
    logic [159:0] digest;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_message_byte   <= data;
    in_byte_present   <= present;
    in_end_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
    if (hash_item(data, present, last, digest)) begin
      if (typed) digest = typed_digest;
      for (int k = 0; k < sha1_pkg::DIGEST_WORDS; k++) begin
        digest_q.push_back('{digest[159 - 32 * k -: 32], 3'(k),
                             3'(k) == sha1_pkg::LAST_WORD});
      end
    end
  endtask

  // Occasional ignored transactions are mixed into the byte stream.
  task automatic send_message(input int len, input bit end_carries_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
      send_item(8'($urandom_range(255)), 1'b1, end_carries_byte && (i == len - 1),
                1'b0, NO_DIGEST);
    end
    if (!end_carries_byte || len == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    end
  endtask

  task automatic wait_for_digests();
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_digest_word();
    digest_word_t exp;
    if (digest_q.size() == 0) begin
      $error("unexpected digest transaction: word %0d value %h", out_word_number,
             out_digest_word);
      fail_count++;
    end else begin
      exp = digest_q.pop_front();
      if (out_digest_word !== exp.digest_word) begin
        $error("digest_word mismatch: expected %h, actual %h", exp.digest_word,
               out_digest_word);
        fail_count++;
      end
      if (out_word_number !== exp.word_number) begin
        $error("word_number mismatch: expected %0d, actual %0d", exp.word_number,
               out_word_number);
        fail_count++;
      end
      if (out_final_word !== exp.final_word) begin
        $error("final_word mismatch: expected %0b, actual %0b", exp.final_word,
               out_final_word);
        fail_count++;
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_digest_word();
      out_ready <= rst_n && ($urandom_range(99) >= take_idle_pct);
    end
  end

  initial begin
    int len;
    int msg_no;
    int phase;
    bit on_end;
    clk               = 1'b0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_message_byte   <= '0;
    in_byte_present   <= 1'b0;
    in_end_of_message <= 1'b0;
    fail_count    = 0;
    item_count    = 0;
    send_idle_pct = 38;
    take_idle_pct = 83;
    phase         = 0;
    msg_no        = 0;
    for (int i = 0; i < 16; i++) msg_words[i] = '0;
    restart_hash();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].message_byte, directed_rows[i].byte_present,
                directed_rows[i].end_of_message, directed_rows[i].typed,
                directed_rows[i].digest);
    end

    // The first three messages sit on the padding boundaries: the length
    // field just fits, it spills into an extra block, and the final byte
    // fills a block so the padding starts a fresh one.
    while (item_count < ITEM_TARGET) begin
      if (phase == 0 && item_count >= ITEM_TARGET / 3) begin
        wait_for_digests();
        send_idle_pct = 83;
        take_idle_pct = 38;
        phase = 1;
      end else if (phase == 1 && item_count >= 2 * ITEM_TARGET / 3) begin
        wait_for_digests();
        send_idle_pct = 0;
        take_idle_pct = 0;
        phase = 2;
      end
      case (msg_no)
        0: begin
          len = 55;
          on_end = 1'b1;
        end
        1: begin
          len = 56;
          on_end = 1'b0;
        end
        2: begin
          len = 64;
          on_end = 1'b1;
        end
        default: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(130, 65) : $urandom_range(24, 0);
          on_end = 1'($urandom_range(1));
        end
      endcase
      send_message(len, on_end);
      msg_no++;
    end

    in_valid <= 1'b0;
    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_hash_engine_core verification clean");
    end else begin
      $display("sha1_hash_engine_core verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("sha1_hash_engine_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
